// ===== hdl/npack_pkg.sv =====
// shared constants for the normal packer
// no dependencies
package npack_pkg;

    localparam int NP_IN_WIDTH = 32;

    localparam logic [9:0]  NP_SCALE_XY = 10'd1023;
    localparam logic [19:0] NP_SCALE_XY_SQ = 20'd1046529;
    localparam logic [19:0] NP_SCALE_Z_SQ = 20'd261121;

    localparam int NP_SHIFT_Y = 11;
    localparam int NP_SHIFT_Z = 22;

    localparam logic [31:0] NP_THRESH_RESET = 32'd429;

    // quantizer search runs over ten magnitude bits
    localparam int NP_QBITS = 10;

    // pipeline stage where the output register sits
    localparam int NP_LAST = 15;

    // register indexes
    localparam logic NP_REG_THRESH = 1'b0;

endpackage

// ===== hdl/npack_in_if.sv =====
// input channel carrying one vector beat
// depends on nothing
interface npack_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic [31:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

// ===== hdl/npack_out_if.sv =====
// output channel carrying one packed normal beat
// depends on nothing
interface npack_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_normal;
    logic        degenerate;

    modport source (output valid, output packed_normal, output degenerate, input ready);
    modport sink (input valid, input packed_normal, input degenerate, output ready);
endinterface

// ===== hdl/npack_lane.sv =====
// one component lane: target product, then bit-per-stage magnitude search
// depends on npack_pkg
module npack_lane (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_narrow,
    input  logic [63:0] i_sq,
    input  logic [63:0] i_len2,
    output logic [9:0]  o_q
);

    logic [19:0] w_scale_sq;
    logic [51:0] r_pl;
    logic [51:0] r_ph;

    logic [84:0] r_a [0:npack_pkg::NP_QBITS];
    logic [73:0] r_b [0:npack_pkg::NP_QBITS];
    logic [63:0] r_l [0:npack_pkg::NP_QBITS];
    logic [83:0] r_r [0:npack_pkg::NP_QBITS];
    logic [9:0]  r_q [0:npack_pkg::NP_QBITS];

    assign w_scale_sq = i_narrow ? npack_pkg::NP_SCALE_Z_SQ : npack_pkg::NP_SCALE_XY_SQ;

    // split m*m*S*S into two narrow products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl <= 52'(i_sq[31:0]) * 52'(w_scale_sq);
            r_ph <= 52'(i_sq[63:32]) * 52'(w_scale_sq);
        end
    end

    // join the target and start the search at zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0] <= {r_ph, 32'd0} + 84'(r_pl);
            r_l[0] <= i_len2;
            r_a[0] <= '0;
            r_b[0] <= '0;
            r_q[0] <= '0;
        end
    end

    // each stage tries one bit: (q+2^b)^2*L = A + 2^(b+1)*B + 2^(2b)*L
    for (genvar k = 1; k <= npack_pkg::NP_QBITS; k++) begin : g_step
        localparam int B = npack_pkg::NP_QBITS - k;
        logic [84:0] w_cand;
        logic        w_take;

        assign w_cand = r_a[k-1] + (85'(r_b[k-1]) << (B + 1)) + (85'(r_l[k-1]) << (2 * B));
        assign w_take = (w_cand <= {1'b0, r_r[k-1]}) && !(i_narrow && (B == 9));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k] <= r_r[k-1];
                r_l[k] <= r_l[k-1];
                if (w_take) begin
                    r_a[k] <= w_cand;
                    r_b[k] <= r_b[k-1] + (74'(r_l[k-1]) << B);
                    r_q[k] <= r_q[k-1] | (10'd1 << B);
                end else begin
                    r_a[k] <= r_a[k-1];
                    r_b[k] <= r_b[k-1];
                    r_q[k] <= r_q[k-1];
                end
            end
        end
    end

    assign o_q = r_q[npack_pkg::NP_QBITS];

endmodule

// ===== hdl/normal_pack_11_11_10_top.sv =====
// Packs the unit normal of a signed Q16.16 vector into one 11/11/10 word.
// A beat is accepted every cycle while the output is not stalled; the
// pipeline is made of the ten-stage bit search per component plus squaring,
// summing and target-product stages. A stall on the output holds the whole
// pipeline, nothing is lost. The squared-length threshold sits at byte
// address 0 of the APB port and resets to 429.
// depends on npack_pkg, npack_in_if, npack_out_if and npack_lane
module normal_pack_11_11_10_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npack_in_if.sink    i_in,
    npack_out_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SH = 32 - npack_pkg::NP_IN_WIDTH;
    localparam int L = npack_pkg::NP_LAST;

    logic        w_en;
    logic [31:0] r_thresh;
    logic        r_vld [1:L];

    logic signed [31:0] w_ex, w_ey, w_ez;
    logic [31:0] r_mx, r_my, r_mz;
    logic [63:0] r_sx, r_sy, r_sz;
    logic [63:0] r_len2;
    logic [2:0]  r_sgn [1:L-1];
    logic        r_deg [4:L-1];
    logic [9:0]  w_qx, w_qy, w_qz;
    logic [31:0] r_packed;
    logic        r_degen;

    assign w_en = !r_vld[L] || o_out.ready;
    assign i_in.ready = w_en;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == npack_pkg::NP_REG_THRESH) ? r_thresh : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= npack_pkg::NP_THRESH_RESET;
        end else if (psel && penable && pwrite && paddr[2] == npack_pkg::NP_REG_THRESH) begin
            r_thresh <= pwdata;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= L; s++) r_vld[s] <= 1'b0;
        end else if (w_en) begin
            r_vld[1] <= i_in.valid;
            for (int s = 2; s <= L; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // sign extension from the used input width
    assign w_ex = $signed(i_in.x_in << SH) >>> SH;
    assign w_ey = $signed(i_in.y_in << SH) >>> SH;
    assign w_ez = $signed(i_in.z_in << SH) >>> SH;

    // magnitudes, squares, the squared length, the degenerate flag and the sign pipes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx <= w_ex[31] ? 32'(-w_ex) : 32'(w_ex);
            r_my <= w_ey[31] ? 32'(-w_ey) : 32'(w_ey);
            r_mz <= w_ez[31] ? 32'(-w_ez) : 32'(w_ez);
            r_sgn[1] <= {w_ez[31], w_ey[31], w_ex[31]};
            r_sx <= 64'(r_mx) * 64'(r_mx);
            r_sy <= 64'(r_my) * 64'(r_my);
            r_sz <= 64'(r_mz) * 64'(r_mz);
            r_len2 <= r_sx + r_sy + r_sz;
            r_deg[4] <= (r_len2 <= 64'(r_thresh));
            for (int s = 2; s <= L - 1; s++) r_sgn[s] <= r_sgn[s-1];
            for (int s = 5; s <= L - 1; s++) r_deg[s] <= r_deg[s-1];
        end
    end

    npack_lane u_lane_x (
        .i_clk(i_clk), .i_en(w_en), .i_narrow(1'b0),
        .i_sq(r_sx), .i_len2(r_len2), .o_q(w_qx)
    );
    npack_lane u_lane_y (
        .i_clk(i_clk), .i_en(w_en), .i_narrow(1'b0),
        .i_sq(r_sy), .i_len2(r_len2), .o_q(w_qy)
    );
    npack_lane u_lane_z (
        .i_clk(i_clk), .i_en(w_en), .i_narrow(1'b1),
        .i_sq(r_sz), .i_len2(r_len2), .o_q(w_qz)
    );

    // output register: apply signs and pack, or give the degenerate default
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_deg[L-1]) begin
                r_packed <= 32'(npack_pkg::NP_SCALE_XY) << npack_pkg::NP_SHIFT_Y;
                r_degen  <= 1'b1;
            end else begin
                r_packed <= 32'(r_sgn[L-1][0] ? 11'(-{1'b0, w_qx}) : {1'b0, w_qx})
                    | (32'(r_sgn[L-1][1] ? 11'(-{1'b0, w_qy}) : {1'b0, w_qy})
                        << npack_pkg::NP_SHIFT_Y)
                    | (32'(r_sgn[L-1][2] ? 10'(-w_qz) : w_qz) << npack_pkg::NP_SHIFT_Z);
                r_degen  <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_vld[L];
    assign o_out.packed_normal = r_packed;
    assign o_out.degenerate = r_degen;

endmodule

// ===== dv/tb_normal_pack_11_11_10_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the 11/11/10 normal packer: directed table, then random vectors
// depends on npack_pkg, npack_in_if, npack_out_if and normal_pack_11_11_10_top
module tb_normal_pack_11_11_10_top;

    localparam int LATENCY   = 20;
    localparam int STALL_MAX = 5000;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic [31:0] packed_normal;
        logic        degenerate;
    } t_normal;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        known;
        t_normal     res;
    } t_vec_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    npack_in_if  in_if ();
    npack_out_if out_if ();

    normal_pack_11_11_10_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_normal     normal_q[$];
    t_normal     typed_q[$];
    logic        typed_flag_q[$];
    logic [31:0] cur_thresh;
    logic        idle_on;
    int          hold_req;
    int          err_cnt;
    int          vec_cnt;
    int          res_cnt;
    int          degen_cnt;
    int          quiet_cyc;

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // largest q <= scale with q*q*len2 <= c*c*scale*scale, two's complement
    function automatic logic [10:0] quantize_comp(logic signed [63:0] c, logic [63:0] len2,
                                                  logic [10:0] scale);
        logic [63:0]  m;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [10:0]  q;
        logic [10:0]  t;
        m = (c < 0) ? -c : c;
        rhs = 128'(m * m) * 128'(32'(scale) * 32'(scale));
        q = '0;
        for (int b = 10; b >= 0; b--) begin
            t = q | (11'd1 << b);
            lhs = 128'(len2) * 128'(32'(t) * 32'(t));
            if (t <= scale && lhs <= rhs) q = t;
        end
        if (c < 0) q = -q;
        return q;
    endfunction

    function automatic t_normal pack_normal(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [31:0] thresh);
        logic signed [63:0] sx, sy, sz;
        logic [63:0] len2;
        logic [10:0] qx, qy, qz;
        t_normal r;
        sx = 64'(signed'(x));
        sy = 64'(signed'(y));
        sz = 64'(signed'(z));
        len2 = sx * sx + sy * sy + sz * sz;
        if (len2 <= 64'(thresh)) begin
            r.packed_normal = 32'(npack_pkg::NP_SCALE_XY) << npack_pkg::NP_SHIFT_Y;
            r.degenerate = 1'b1;
        end else begin
            qx = quantize_comp(sx, len2, 11'd1023);
            qy = quantize_comp(sy, len2, 11'd1023);
            qz = quantize_comp(sz, len2, 11'd511);
            r.packed_normal = {qz[9:0], qy, qx};
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, res_cnt);
        err_cnt++;
    endtask

    // beat monitor, predictor and checker
    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n) begin
            quiet_cyc++;
            if (in_if.valid && in_if.ready) begin
                want = pack_normal(in_if.x_in, in_if.y_in, in_if.z_in, cur_thresh);
                if (typed_flag_q.size() != 0 && typed_flag_q.pop_front()) begin
                    if (typed_q[0] !== want)
                        report_mismatch("table vs predictor", typed_q[0].packed_normal,
                                        want.packed_normal);
                    want = typed_q.pop_front();
                end
                normal_q.insert(normal_q.size(), want);
                vec_cnt++;
                quiet_cyc = 0;
            end
            if (out_if.valid && out_if.ready) begin
                quiet_cyc = 0;
                if (normal_q.size() == 0) begin
                    report_mismatch("unexpected beat", out_if.packed_normal, '0);
                end else begin
                    want = normal_q.pop_front();
                    if (out_if.packed_normal !== want.packed_normal)
                        report_mismatch("packed_normal", out_if.packed_normal,
                                        want.packed_normal);
                    if (out_if.degenerate !== want.degenerate)
                        report_mismatch("degenerate", 32'(out_if.degenerate),
                                        32'(want.degenerate));
                    if (want.degenerate) degen_cnt++;
                end
                res_cnt++;
            end
            if (quiet_cyc >= STALL_MAX) begin
                $display("watchdog: no beat for %0d cycles", STALL_MAX);
                $display("tb_normal_pack_11_11_10_top: done, errors");
                $finish;
            end
        end
    end

    // receiver ready with random stalls and one long hold-off
    always @(negedge i_clk) begin
        int   hold_left;
        logic hold_done;
        if (hold_req != 0 && hold_done !== 1'b1) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (idle_on) begin
            out_if.ready <= ($urandom_range(99) >= 34);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // offer one vector, return at the negedge after it is taken
    task automatic drive_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (idle_on && $urandom_range(99) < 34) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.x_in <= x;
        in_if.y_in <= y;
        in_if.z_in <= z;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // drain, let the pipeline settle, then write the threshold
    task automatic write_thresh(logic [31:0] value);
        in_if.valid <= 1'b0;
        while (normal_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(npack_pkg::NP_REG_THRESH) * 3'd4;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cur_thresh = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_comp();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 40));
            default: v = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    task automatic random_vectors(int count);
        for (int i = 0; i < count; i++) drive_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    t_vec_row dir_rows[$];

    task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic known,
                           logic [31:0] pn, logic dg);
        t_vec_row r;
        r.x = x;
        r.y = y;
        r.z = z;
        r.known = known;
        r.res.packed_normal = pn;
        r.res.degenerate = dg;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.x_in = '0;
        in_if.y_in = '0;
        in_if.z_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_thresh = npack_pkg::NP_THRESH_RESET;
        idle_on = 1'b1;
        hold_req = 0;
        err_cnt = 0;
        vec_cnt = 0;
        res_cnt = 0;
        degen_cnt = 0;
        quiet_cyc = 0;

        // directed vectors, expected value typed where obvious
        add_row(32'h0, 32'h0, 32'h0, 1'b1, 32'h001FF800, 1'b1);
        add_row(32'h10000, 32'h0, 32'h0, 1'b1, 32'h000003FF, 1'b0);
        add_row(32'hFFFF0000, 32'h0, 32'h0, 1'b1, 32'h00000401, 1'b0);
        add_row(32'h0, 32'h10000, 32'h0, 1'b1, 32'h001FF800, 1'b0);
        add_row(32'h0, 32'hFFFF0000, 32'h0, 1'b1, 32'h00200800, 1'b0);
        add_row(32'h0, 32'h0, 32'h10000, 1'b1, 32'h7FC00000, 1'b0);
        add_row(32'h0, 32'h0, 32'hFFFF0000, 1'b1, 32'h80400000, 1'b0);
        add_row(32'h7FFFFFFF, 32'h0, 32'h0, 1'b1, 32'h000003FF, 1'b0);
        add_row(32'h80000000, 32'h0, 32'h0, 1'b1, 32'h00000401, 1'b0);
        add_row(32'h0, 32'h0, 32'h80000000, 1'b1, 32'h80400000, 1'b0);
        // length squared just at and just above the reset threshold
        add_row(32'd20, 32'd2, 32'd5, 1'b1, 32'h001FF800, 1'b1);
        add_row(32'd21, 32'h0, 32'h0, 1'b1, 32'h000003FF, 1'b0);
        add_row(32'hFFFFFFFF, 32'h0, 32'h0, 1'b1, 32'h001FF800, 1'b1);
        add_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, '0, 1'b0);
        add_row(32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '0, 1'b0);
        add_row(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0, 1'b0);
        add_row(32'h10000, 32'h10000, 32'h10000, 1'b0, '0, 1'b0);
        add_row(32'hFFFF0000, 32'h10000, 32'hFFFF0000, 1'b0, '0, 1'b0);
        add_row(32'h30000, 32'h40000, 32'h0, 1'b0, '0, 1'b0);
        add_row(32'h5555AAAA, 32'hAAAA5555, 32'h12345678, 1'b0, '0, 1'b0);
        add_row(32'd1, 32'd1, 32'hFFFFFFE3, 1'b0, '0, 1'b0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            typed_flag_q.insert(typed_flag_q.size(), dir_rows[i].known);
            if (dir_rows[i].known) typed_q.insert(typed_q.size(), dir_rows[i].res);
            drive_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
        end
        random_vectors(180);

        // threshold zero: everything but the zero vector normalizes
        write_thresh(32'h0);
        drive_vector(32'd0, 32'd0, 32'd0);
        drive_vector(32'd1, 32'd0, 32'd0);
        hold_req = 1;
        random_vectors(170);

        // largest threshold, no idling on either side
        write_thresh(32'hFFFFFFFF);
        idle_on = 1'b0;
        random_vectors(150);
        idle_on = 1'b1;

        // a few random thresholds
        for (int p = 0; p < 3; p++) begin
            write_thresh($urandom >> $urandom_range(31));
            random_vectors(80);
        end

        in_if.valid <= 1'b0;
        while (normal_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);

        $display("covered %0d vectors, %0d results (%0d short), thresholds 429/0/max/random",
                 vec_cnt, res_cnt, degen_cnt);
        if (err_cnt == 0) begin
            $display("tb_normal_pack_11_11_10_top: done, clean");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("tb_normal_pack_11_11_10_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== normal_pack_11_11_10_top.f =====
hdl/npack_pkg.sv
hdl/npack_in_if.sv
hdl/npack_out_if.sv
hdl/npack_lane.sv
hdl/normal_pack_11_11_10_top.sv
dv/tb_normal_pack_11_11_10_top.sv
